// ===== rtl/rgbc_color_classifier_unit_defines.svh =====
`ifndef RGBC_COLOR_CLASSIFIER_UNIT_DEFINES_SVH
`define RGBC_COLOR_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RGBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RGBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbc assertion failed");

`endif

// ===== rtl/rgbc_pkg.sv =====
package rgbc_pkg;

    localparam int FRAC = 16;
    localparam int DIV_STEPS = 18;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [17:0] RATIO_MAX = 18'h3FFFF;
    localparam logic [23:0] INTENSITY_MAX = 24'hFFFFFF;

    localparam logic [23:0] FX_1_1   = 24'(((1 << FRAC) + 1 / 2) / 1);
    localparam logic [23:0] FX_1_5   = 24'(((1 << FRAC) + 5 / 2) / 5);
    localparam logic [23:0] FX_3_20  = 24'(((3 << FRAC) + 20 / 2) / 20);
    localparam logic [23:0] FX_1_20  = 24'(((1 << FRAC) + 20 / 2) / 20);
    localparam logic [23:0] FX_2_5   = 24'(((2 << FRAC) + 5 / 2) / 5);
    localparam logic [23:0] FX_3_4   = 24'(((3 << FRAC) + 4 / 2) / 4);
    localparam logic [23:0] FX_1_4   = 24'(((1 << FRAC) + 4 / 2) / 4);
    localparam logic [23:0] FX_1_10  = 24'(((1 << FRAC) + 10 / 2) / 10);
    localparam logic [23:0] FX_4_5   = 24'(((4 << FRAC) + 5 / 2) / 5);

    localparam logic [2:0] CFG_CLEAR_SCALE = 3'd0;
    localparam logic [2:0] CFG_RED_SCALE   = 3'd1;
    localparam logic [2:0] CFG_GREEN_SCALE = 3'd2;
    localparam logic [2:0] CFG_BLUE_SCALE  = 3'd3;
    localparam logic [2:0] CFG_NEUTRAL_TOL = 3'd4;

    typedef enum logic [2:0] {
        COLOR_WHITE   = 3'd0,
        COLOR_BLACK   = 3'd1,
        COLOR_GRAY    = 3'd2,
        COLOR_RED     = 3'd3,
        COLOR_GREEN   = 3'd4,
        COLOR_BLUE    = 3'd5,
        COLOR_YELLOW  = 3'd6,
        COLOR_UNKNOWN = 3'd7
    } t_color;

    typedef struct packed {
        logic [31:0] clear_scale;
        logic [17:0] red_scale;
        logic [17:0] green_scale;
        logic [17:0] blue_scale;
        logic [15:0] neutral_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [15:0] raw_clear;
        logic [15:0] raw_blue;
        logic [15:0] raw_green;
        logic [15:0] raw_red;
    } t_sample;

    typedef struct packed {
        t_color      color_code;
        logic [17:0] red_ratio;
        logic [17:0] green_ratio;
        logic [17:0] blue_ratio;
        logic [23:0] intensity_ratio;
        logic        zero_clear;
    } t_result;

    typedef struct packed {
        logic [15:0] rem;
        logic [17:0] q;
    } t_div;

    function automatic t_div div_step(input t_div s, input logic [15:0] d);
        logic [16:0] t;
        logic        ge;
        t_div        o;
        t = {s.rem, s.q[17]};
        ge = (t >= {1'b0, d});
        o.rem = ge ? 16'(t - {1'b0, d}) : t[15:0];
        o.q = {s.q[16:0], ge};
        return o;
    endfunction

    function automatic logic near_to(input logic [23:0] a, input logic [23:0] b,
                                     input logic [23:0] tol);
        logic [23:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

endpackage

// ===== rtl/rgbc_front.sv =====
module rgbc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rgbc_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  rgbc_pkg::t_sample i_sample,
    output logic             o_valid,
    output rgbc_pkg::t_result o_result,
    input  logic             i_ready
);

    localparam int S_DIV0 = 1;
    localparam int S_RAT  = S_DIV0 + rgbc_pkg::DIV_STEPS + 1;
    localparam int S_FLG  = S_RAT + 1;
    localparam int NST    = S_FLG + 2;

    typedef struct packed {
        logic nt;
        logic n15;
        logic c_white;
        logic c_black;
        logic c_gray;
        logic dim;
        logic r_red;
        logic gb;
        logic g_dom;
        logic b_dom;
        logic y_dom;
        logic c_yel;
    } t_flags;

    logic              r_v [0:NST-1];
    logic              en;

    logic [33:0]       r_num [0:2];
    logic [47:0]       r_cprod;
    logic [15:0]       r_clr;

    rgbc_pkg::t_div    r_div [0:2][0:rgbc_pkg::DIV_STEPS];
    logic              r_sat [0:2][0:rgbc_pkg::DIV_STEPS];
    logic [15:0]       r_dv  [0:rgbc_pkg::DIV_STEPS];
    logic [23:0]       r_int [0:rgbc_pkg::DIV_STEPS];
    logic              r_zc  [0:rgbc_pkg::DIV_STEPS];

    logic [17:0]       r_rat [0:2];
    logic [23:0]       r_c;
    logic              r_zc_r;

    t_flags            r_fl;
    logic [17:0]       r_rat_f [0:2];
    logic [23:0]       r_c_f;
    logic              r_zc_f;

    rgbc_pkg::t_result r_res;

    assign en = !r_v[NST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[NST-1];
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num[0] <= i_sample.raw_red * i_cfg.red_scale;
            r_num[1] <= i_sample.raw_green * i_cfg.green_scale;
            r_num[2] <= i_sample.raw_blue * i_cfg.blue_scale;
            r_cprod <= i_sample.raw_clear * i_cfg.clear_scale;
            r_clr <= i_sample.raw_clear;

            for (int ch = 0; ch < 3; ch++) begin
                r_div[ch][0].rem <= r_num[ch][33:18];
                r_div[ch][0].q <= r_num[ch][17:0];
                r_sat[ch][0] <= (r_num[ch][33:18] >= r_clr);
            end
            r_dv[0] <= r_clr;
            r_int[0] <= (r_cprod[47:32] != 16'd0) ? rgbc_pkg::INTENSITY_MAX : r_cprod[31:8];
            r_zc[0] <= (r_clr == 16'd0);

            for (int k = 0; k < rgbc_pkg::DIV_STEPS; k++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    r_div[ch][k+1] <= rgbc_pkg::div_step(r_div[ch][k], r_dv[k]);
                    r_sat[ch][k+1] <= r_sat[ch][k];
                end
                r_dv[k+1] <= r_dv[k];
                r_int[k+1] <= r_int[k];
                r_zc[k+1] <= r_zc[k];
            end

            for (int ch = 0; ch < 3; ch++) begin
                r_rat[ch] <= r_sat[ch][rgbc_pkg::DIV_STEPS] ? rgbc_pkg::RATIO_MAX
                                                             : r_div[ch][rgbc_pkg::DIV_STEPS].q;
            end
            r_c <= r_int[rgbc_pkg::DIV_STEPS];
            r_zc_r <= r_zc[rgbc_pkg::DIV_STEPS];
        end
    end

    logic [23:0] r24, g24, b24, ntol;
    logic [20:0] r21, g21, b21;
    t_flags      n_fl;

    assign r24 = {6'd0, r_rat[0]};
    assign g24 = {6'd0, r_rat[1]};
    assign b24 = {6'd0, r_rat[2]};
    assign r21 = {3'd0, r_rat[0]};
    assign g21 = {3'd0, r_rat[1]};
    assign b21 = {3'd0, r_rat[2]};
    assign ntol = {8'd0, i_cfg.neutral_tolerance};

    always_comb begin
        n_fl.nt = rgbc_pkg::near_to(r24, g24, ntol) && rgbc_pkg::near_to(r24, b24, ntol)
                  && rgbc_pkg::near_to(g24, b24, ntol);
        n_fl.n15 = rgbc_pkg::near_to(r24, g24, rgbc_pkg::FX_3_20)
                   && rgbc_pkg::near_to(r24, b24, rgbc_pkg::FX_3_20)
                   && rgbc_pkg::near_to(g24, b24, rgbc_pkg::FX_3_20);
        n_fl.c_white = rgbc_pkg::near_to(r_c, rgbc_pkg::FX_1_1, rgbc_pkg::FX_3_20);
        n_fl.c_black = rgbc_pkg::near_to(r_c, rgbc_pkg::FX_1_20, rgbc_pkg::FX_1_20);
        n_fl.c_gray = rgbc_pkg::near_to(r_c, rgbc_pkg::FX_2_5, rgbc_pkg::FX_3_20);
        n_fl.dim = rgbc_pkg::near_to(r_c, rgbc_pkg::FX_1_5, rgbc_pkg::FX_1_5);
        n_fl.r_red = rgbc_pkg::near_to(r24, rgbc_pkg::FX_3_4, rgbc_pkg::FX_1_4);
        n_fl.gb = rgbc_pkg::near_to(g24, b24, rgbc_pkg::FX_1_10);
        n_fl.g_dom = (r_rat[1] != 18'd0) && ((g21 << 1) >= ((r21 << 1) + r21));
        n_fl.b_dom = (r_rat[2] != 18'd0) && ((b21 << 1) >= ((r21 << 2) + r21));
        n_fl.y_dom = (r_rat[0] != 18'd0) && ((r21 << 1) >= ((b21 << 2) + b21));
        n_fl.c_yel = rgbc_pkg::near_to(r_c, rgbc_pkg::FX_4_5, rgbc_pkg::FX_1_5);
    end

    rgbc_pkg::t_color n_code;

    always_comb begin
        if (r_zc_f) begin
            n_code = rgbc_pkg::COLOR_UNKNOWN;
        end else if (r_fl.nt && r_fl.c_white) begin
            n_code = rgbc_pkg::COLOR_WHITE;
        end else if (r_fl.n15 && r_fl.c_black) begin
            n_code = rgbc_pkg::COLOR_BLACK;
        end else if (r_fl.nt && r_fl.c_gray) begin
            n_code = rgbc_pkg::COLOR_GRAY;
        end else if (r_fl.r_red && r_fl.gb && r_fl.dim) begin
            n_code = rgbc_pkg::COLOR_RED;
        end else if (r_fl.g_dom && r_fl.gb && r_fl.dim) begin
            n_code = rgbc_pkg::COLOR_GREEN;
        end else if (r_fl.b_dom && r_fl.dim) begin
            n_code = rgbc_pkg::COLOR_BLUE;
        end else if (r_fl.y_dom && r_fl.c_yel) begin
            n_code = rgbc_pkg::COLOR_YELLOW;
        end else begin
            n_code = rgbc_pkg::COLOR_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fl <= n_fl;
            for (int ch = 0; ch < 3; ch++) begin
                r_rat_f[ch] <= r_rat[ch];
            end
            r_c_f <= r_c;
            r_zc_f <= r_zc_r;

            r_res.color_code <= n_code;
            r_res.red_ratio <= r_zc_f ? 18'd0 : r_rat_f[0];
            r_res.green_ratio <= r_zc_f ? 18'd0 : r_rat_f[1];
            r_res.blue_ratio <= r_zc_f ? 18'd0 : r_rat_f[2];
            r_res.intensity_ratio <= r_zc_f ? 24'd0 : r_c_f;
            r_res.zero_clear <= r_zc_f;
        end
    end

endmodule

// ===== rtl/rgbc_queue.sv =====
`include "rgbc_color_classifier_unit_defines.svh"

module rgbc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    output logic              o_ready,
    input  rgbc_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_rd,
    output rgbc_pkg::t_result o_data
);

    rgbc_pkg::t_result             r_mem [0:rgbc_pkg::QUEUE_DEPTH-1];
    logic [rgbc_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [rgbc_pkg::QPTR_W:0]     r_cnt;
    logic                          wr, rd;

    assign o_ready = (r_cnt != (rgbc_pkg::QPTR_W+1)'(rgbc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr = i_wr && o_ready;
    assign rd = i_rd && o_valid;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `RGBC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (rgbc_pkg::QPTR_W+1)'(rgbc_pkg::QUEUE_DEPTH))
    `RGBC_ASSERT_NXT(a_cnt_inc, i_clk, i_rst_n, wr && !rd, r_cnt == $past(r_cnt) + 1'b1)
    `RGBC_ASSERT_NXT(a_cnt_dec, i_clk, i_rst_n, rd && !wr, r_cnt == $past(r_cnt) - 1'b1)

endmodule

// ===== rtl/rgbc_back.sv =====
module rgbc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_rd,
    input  rgbc_pkg::t_result i_q_data,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [87:0]       o_tdata,
    output logic [0:0]        o_tuser
);

    logic        r_valid;
    logic [87:0] r_data;
    logic        r_user;
    logic        load;

    assign load = !r_valid || i_tready;
    assign o_q_rd = load && i_q_valid;
    assign o_tvalid = r_valid;
    assign o_tdata = r_data;
    assign o_tuser = r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_data <= {7'd0, i_q_data.intensity_ratio, i_q_data.blue_ratio,
                       i_q_data.green_ratio, i_q_data.red_ratio, i_q_data.color_code};
            r_user <= i_q_data.zero_clear;
        end
    end

endmodule

// ===== rtl/rgbc_color_classifier_unit.sv =====
// Color classifier for raw red, green, blue and clear sensor counts.
// The slave stream takes one sample per beat; the master stream gives one
// result beat per sample, in order. The config channel writes one register
// per beat by index: 0 clear scale, 1 red, 2 green, 3 blue scale, 4 neutral
// tolerance; other indexes are ignored. It is always ready and should only
// be used while no sample is in flight.
// A sample is accepted every cycle while the output side keeps up. The
// front pipeline has a one-bit-per-stage restoring divider of 18 stages
// per channel; a result beat passes the multiply, divider, ratio and
// classification stages, then the four-entry queue and the output register.
// When the receiver stalls, the output register and queue fill, then the
// front pipeline freezes and o_s_axis_tready drops; no beat is lost.
// Reset clears all valid state and loads the default register values.
module rgbc_color_classifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // raw_red, raw_green, raw_blue, raw_clear
    input  logic [63:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // color_code, red_ratio, green_ratio, blue_ratio, intensity_ratio, zero pad
    output logic [87:0] o_m_axis_tdata,
    // zero_clear
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rgbc_pkg::t_cfg    r_cfg;
    rgbc_pkg::t_result f_res, q_res;
    logic              f_valid, q_ready, q_valid, q_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clear_scale <= 32'd54578;
            r_cfg.red_scale <= 18'd70687;
            r_cfg.green_scale <= 18'd63955;
            r_cfg.blue_scale <= 18'd69921;
            r_cfg.neutral_tolerance <= 16'd6554;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rgbc_pkg::CFG_CLEAR_SCALE: r_cfg.clear_scale <= i_cfg_data;
                rgbc_pkg::CFG_RED_SCALE:   r_cfg.red_scale <= i_cfg_data[17:0];
                rgbc_pkg::CFG_GREEN_SCALE: r_cfg.green_scale <= i_cfg_data[17:0];
                rgbc_pkg::CFG_BLUE_SCALE:  r_cfg.blue_scale <= i_cfg_data[17:0];
                rgbc_pkg::CFG_NEUTRAL_TOL: r_cfg.neutral_tolerance <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    rgbc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample (rgbc_pkg::t_sample'(i_s_axis_tdata)),
        .o_valid  (f_valid),
        .o_result (f_res),
        .i_ready  (q_ready)
    );

    rgbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .o_ready (q_ready),
        .i_data  (f_res),
        .o_valid (q_valid),
        .i_rd    (q_rd),
        .o_data  (q_res)
    );

    rgbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_rd    (q_rd),
        .i_q_data  (q_res),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser)
    );

endmodule

// ===== tb/tb_rgbc_color_classifier_unit.sv =====
module tb_rgbc_color_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic [63:0] K_1_1  = ((64'd1 << 16) + 64'd0) / 64'd1;
    localparam logic [63:0] K_1_5  = ((64'd1 << 16) + 64'd2) / 64'd5;
    localparam logic [63:0] K_3_20 = ((64'd3 << 16) + 64'd10) / 64'd20;
    localparam logic [63:0] K_1_20 = ((64'd1 << 16) + 64'd10) / 64'd20;
    localparam logic [63:0] K_2_5  = ((64'd2 << 16) + 64'd2) / 64'd5;
    localparam logic [63:0] K_3_4  = ((64'd3 << 16) + 64'd2) / 64'd4;
    localparam logic [63:0] K_1_4  = ((64'd1 << 16) + 64'd2) / 64'd4;
    localparam logic [63:0] K_1_10 = ((64'd1 << 16) + 64'd5) / 64'd10;
    localparam logic [63:0] K_4_5  = ((64'd4 << 16) + 64'd2) / 64'd5;

    typedef struct packed {
        rgbc_pkg::t_color color;
        logic [17:0]      red_ratio;
        logic [17:0]      green_ratio;
        logic [17:0]      blue_ratio;
        logic [23:0]      intensity;
        logic             zero_clear;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = rgbc_pkg::CFG_CLEAR_SCALE;
    logic [31:0] cfg_data = '0;
    logic        o_s_axis_tready, o_m_axis_tvalid, o_cfg_ready;
    logic [87:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    logic [31:0] clear_scale;
    logic [17:0] red_scale, green_scale, blue_scale;
    logic [15:0] neutral_tol;

    logic [63:0] pending_samples[$];
    t_reading    expected_readings[$];
    int          src_gap = 0;
    int          snk_gap = 0;
    bit          no_stalls = 0;
    int          errors = 0;
    int          cycles = 0;
    int          checked = 0;
    int          color_hits[8];

    rgbc_color_classifier_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit close(input logic [63:0] a, input logic [63:0] b,
                                 input logic [63:0] tol);
        return ((a > b) ? (a - b) : (b - a)) <= tol;
    endfunction

    function automatic bit neutral(input logic [63:0] r, input logic [63:0] g,
                                   input logic [63:0] b, input logic [63:0] tol);
        return close(r, g, tol) && close(r, b, tol) && close(g, b, tol);
    endfunction

    function automatic rgbc_pkg::t_color classify(input logic [63:0] r, input logic [63:0] g,
                                                  input logic [63:0] b, input logic [63:0] c);
        logic [63:0] ntol;
        bit          dim;
        ntol = {48'd0, neutral_tol};
        dim = close(c, K_1_5, K_1_5);
        if (neutral(r, g, b, ntol) && close(c, K_1_1, K_3_20)) return rgbc_pkg::COLOR_WHITE;
        if (neutral(r, g, b, K_3_20) && close(c, K_1_20, K_1_20)) return rgbc_pkg::COLOR_BLACK;
        if (neutral(r, g, b, ntol) && close(c, K_2_5, K_3_20)) return rgbc_pkg::COLOR_GRAY;
        if (close(r, K_3_4, K_1_4) && close(g, b, K_1_10) && dim) return rgbc_pkg::COLOR_RED;
        if (g != 64'd0 && 64'd2 * g >= 64'd3 * r && close(g, b, K_1_10) && dim)
            return rgbc_pkg::COLOR_GREEN;
        if (b != 64'd0 && 64'd2 * b >= 64'd5 * r && dim) return rgbc_pkg::COLOR_BLUE;
        if (r != 64'd0 && 64'd2 * r >= 64'd5 * b && close(c, K_4_5, K_1_5))
            return rgbc_pkg::COLOR_YELLOW;
        return rgbc_pkg::COLOR_UNKNOWN;
    endfunction

    function automatic logic [17:0] balance(input logic [15:0] raw, input logic [17:0] scale,
                                            input logic [15:0] clr);
        logic [63:0] q;
        q = (64'(raw) * 64'(scale)) / 64'(clr);
        return (q > 64'h3FFFF) ? 18'h3FFFF : q[17:0];
    endfunction

    function automatic t_reading predict_reading(input logic [63:0] smp);
        t_reading    res;
        logic [15:0] clr;
        logic [63:0] c;
        clr = smp[63:48];
        if (clr == 16'd0) begin
            res = '{rgbc_pkg::COLOR_UNKNOWN, 18'd0, 18'd0, 18'd0, 24'd0, 1'b1};
            return res;
        end
        res.red_ratio = balance(smp[15:0], red_scale, clr);
        res.green_ratio = balance(smp[31:16], green_scale, clr);
        res.blue_ratio = balance(smp[47:32], blue_scale, clr);
        c = (64'(clr) * 64'(clear_scale)) >> 8;
        res.intensity = (c > 64'hFFFFFF) ? 24'hFFFFFF : c[23:0];
        res.zero_clear = 1'b0;
        res.color = classify(64'(res.red_ratio), 64'(res.green_ratio), 64'(res.blue_ratio),
                             64'(res.intensity));
        return res;
    endfunction

    function automatic logic [15:0] raw_for(input logic [63:0] ratio, input logic [15:0] clr,
                                            input logic [17:0] scale);
        logic [63:0] v;
        if (scale == 18'd0) return 16'($urandom);
        v = (ratio * 64'(clr) + 64'(scale) - 64'd1) / 64'(scale);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // Builds a sample aimed at one color class, with jitter around each window.
    function automatic logic [63:0] aimed_sample(input rgbc_pkg::t_color want);
        logic [63:0] inten, r, g, b, base, jit;
        logic [63:0] clr64;
        logic [15:0] clr;
        jit = K_1_10;
        case (want)
            rgbc_pkg::COLOR_WHITE:  inten = K_1_1;
            rgbc_pkg::COLOR_BLACK:  inten = K_1_20;
            rgbc_pkg::COLOR_GRAY:   inten = K_2_5;
            rgbc_pkg::COLOR_YELLOW: inten = K_4_5;
            default:                inten = K_1_5;
        endcase
        inten = inten + 64'($urandom_range(0, 2 * 13107)) - 64'd13107;
        if (inten[63]) inten = 64'd1;
        clr64 = (clear_scale == 32'd0) ? 64'($urandom_range(1, 65535))
                                       : ((inten << 8) / 64'(clear_scale));
        clr = (clr64 == 64'd0) ? 16'd1 : (clr64 > 64'd65535) ? 16'hFFFF : clr64[15:0];
        base = 64'($urandom_range(0, 2 * 65536));
        r = base + 64'($urandom_range(0, 32'(2 * jit))) - jit;
        g = base + 64'($urandom_range(0, 32'(2 * jit))) - jit;
        b = base + 64'($urandom_range(0, 32'(2 * jit))) - jit;
        case (want)
            rgbc_pkg::COLOR_RED: begin
                r = 64'($urandom_range(32'(K_3_4 - K_1_4 - 64'd2000),
                                       32'(K_3_4 + K_1_4 + 64'd2000)));
                g = 64'($urandom_range(0, 65536));
                b = g + 64'($urandom_range(0, 32'(2 * jit))) - jit;
            end
            rgbc_pkg::COLOR_GREEN: begin
                r = 64'($urandom_range(0, 40000));
                g = (64'd3 * r) / 64'd2 + 64'($urandom_range(0, 20000)) - 64'd10000;
                b = g + 64'($urandom_range(0, 32'(2 * jit))) - jit;
            end
            rgbc_pkg::COLOR_BLUE: begin
                r = 64'($urandom_range(0, 30000));
                b = (64'd5 * r) / 64'd2 + 64'($urandom_range(0, 20000)) - 64'd10000;
                g = 64'($urandom_range(0, 131072));
            end
            rgbc_pkg::COLOR_YELLOW: begin
                b = 64'($urandom_range(0, 30000));
                r = (64'd5 * b) / 64'd2 + 64'($urandom_range(0, 20000)) - 64'd10000;
                g = 64'($urandom_range(0, 131072));
            end
            default: ;
        endcase
        if (r[63]) r = 64'd0;
        if (g[63]) g = 64'd0;
        if (b[63]) b = 64'd0;
        return {clr, raw_for(b, clr, blue_scale), raw_for(g, clr, green_scale),
                raw_for(r, clr, red_scale)};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (!s_tvalid || o_s_axis_tready) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_samples.pop_front();
                if (!no_stalls && $urandom_range(0, 14) == 0)
                    src_gap <= int'($urandom_range(1, 9));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            snk_gap <= 0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!no_stalls && $urandom_range(0, 11) == 0)
                snk_gap <= int'($urandom_range(1, 9));
        end
    end

    always @(posedge i_clk) begin
        t_reading    exp_r;
        t_reading    got;
        if (i_rst_n && s_tvalid && o_s_axis_tready)
            expected_readings.push_back(predict_reading(s_tdata));
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.color = rgbc_pkg::t_color'(o_m_axis_tdata[2:0]);
            got.red_ratio = o_m_axis_tdata[20:3];
            got.green_ratio = o_m_axis_tdata[38:21];
            got.blue_ratio = o_m_axis_tdata[56:39];
            got.intensity = o_m_axis_tdata[80:57];
            got.zero_clear = o_m_axis_tuser[0];
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_readings.pop_front();
                checked++;
                color_hits[exp_r.color]++;
                if (got.color !== exp_r.color)
                    $display("%0t: color expected %0d actual %0d", $time, exp_r.color,
                             got.color);
                if (got.red_ratio !== exp_r.red_ratio)
                    $display("%0t: red_ratio expected %0d actual %0d", $time,
                             exp_r.red_ratio, got.red_ratio);
                if (got.green_ratio !== exp_r.green_ratio)
                    $display("%0t: green_ratio expected %0d actual %0d", $time,
                             exp_r.green_ratio, got.green_ratio);
                if (got.blue_ratio !== exp_r.blue_ratio)
                    $display("%0t: blue_ratio expected %0d actual %0d", $time,
                             exp_r.blue_ratio, got.blue_ratio);
                if (got.intensity !== exp_r.intensity)
                    $display("%0t: intensity expected %0d actual %0d", $time,
                             exp_r.intensity, got.intensity);
                if (got.zero_clear !== exp_r.zero_clear)
                    $display("%0t: zero_clear expected %0b actual %0b", $time,
                             exp_r.zero_clear, got.zero_clear);
                if (got !== exp_r)
                    errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_samples.size() > 0 || s_tvalid || expected_readings.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            rgbc_pkg::CFG_CLEAR_SCALE: clear_scale = val;
            rgbc_pkg::CFG_RED_SCALE:   red_scale = val[17:0];
            rgbc_pkg::CFG_GREEN_SCALE: green_scale = val[17:0];
            rgbc_pkg::CFG_BLUE_SCALE:  blue_scale = val[17:0];
            rgbc_pkg::CFG_NEUTRAL_TOL: neutral_tol = val[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [31:0] cs, input logic [17:0] rs,
                                 input logic [17:0] gs, input logic [17:0] bs,
                                 input logic [15:0] tol);
        write_reg(rgbc_pkg::CFG_CLEAR_SCALE, cs);
        write_reg(rgbc_pkg::CFG_RED_SCALE, {14'($urandom), rs});
        write_reg(rgbc_pkg::CFG_GREEN_SCALE, {14'($urandom), gs});
        write_reg(rgbc_pkg::CFG_BLUE_SCALE, {14'($urandom), bs});
        write_reg(rgbc_pkg::CFG_NEUTRAL_TOL, {16'($urandom), tol});
        write_reg(3'($urandom_range(5, 7)), $urandom);
    endtask

    task automatic queue_random(input int count);
        int k;
        for (int n = 0; n < count; n++) begin
            k = int'($urandom_range(0, 9));
            if (k < 7)
                pending_samples.push_back(
                    aimed_sample(rgbc_pkg::t_color'($urandom_range(0, 6))));
            else if (k == 7)
                pending_samples.push_back({$urandom, $urandom});
            else
                pending_samples.push_back({16'($urandom_range(0, 3)), 16'($urandom),
                                           16'($urandom), 16'($urandom)});
        end
    endtask

    initial begin
        clear_scale = 32'd54578;
        red_scale = 18'd70687;
        green_scale = 18'd63955;
        blue_scale = 18'd69921;
        neutral_tol = 16'd6554;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        pending_samples.push_back({16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_samples.push_back({16'd0, 48'd0});
        pending_samples.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_samples.push_back({16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_samples.push_back({16'd1, 48'd0});
        pending_samples.push_back({16'hFFFF, 48'd0});
        pending_samples.push_back({16'd300, 16'd0, 16'd0, 16'd0});
        pending_samples.push_back({16'd60, 16'd0, 16'd0, 16'd0});
        for (int c = 0; c <= 6; c++) begin
            pending_samples.push_back(aimed_sample(rgbc_pkg::t_color'(c)));
            pending_samples.push_back(aimed_sample(rgbc_pkg::t_color'(c)));
        end
        wait_idle();

        queue_random(380);
        wait_idle();
        load_settings(32'hFFFFFFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 16'hFFFF);
        queue_random(340);
        wait_idle();
        load_settings(32'd0, 18'd0, 18'd0, 18'd0, 16'd0);
        queue_random(300);
        wait_idle();
        load_settings(32'($urandom_range(20000, 200000)), 18'($urandom_range(40000, 100000)),
                      18'($urandom_range(40000, 100000)), 18'($urandom_range(40000, 100000)),
                      16'($urandom_range(0, 20000)));
        queue_random(420);
        wait_idle();
        load_settings(32'd54578, 18'd70687, 18'd63955, 18'd69921, 16'd6554);
        no_stalls = 1;
        queue_random(390);
        wait_idle();

        $display("Checked %0d result beats across five register settings.", checked);
        $display("Colors seen: W%0d K%0d G%0d R%0d Gn%0d B%0d Y%0d U%0d",
                 color_hits[rgbc_pkg::COLOR_WHITE], color_hits[rgbc_pkg::COLOR_BLACK],
                 color_hits[rgbc_pkg::COLOR_GRAY], color_hits[rgbc_pkg::COLOR_RED],
                 color_hits[rgbc_pkg::COLOR_GREEN], color_hits[rgbc_pkg::COLOR_BLUE],
                 color_hits[rgbc_pkg::COLOR_YELLOW], color_hits[rgbc_pkg::COLOR_UNKNOWN]);
        if (errors == 0 && expected_readings.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rgbc_pkg.sv
rtl/rgbc_front.sv
rtl/rgbc_queue.sv
rtl/rgbc_back.sv
rtl/rgbc_color_classifier_unit.sv
tb/tb_rgbc_color_classifier_unit.sv
